// ----- hdl/hpd_pkg.sv -----
// Package for the planar pixel decoder: widths, codes, shared types and helpers.
// Used by the channel interfaces and every module of the decoder; depends on nothing.
package hpd_pkg;

  localparam int MAP_ENTRIES = 16;
  localparam int MAP_AW      = $clog2(MAP_ENTRIES);
  localparam int MAX_PLANES  = 24;
  localparam int PIX_W       = 24;
  localparam int COL_W       = 8;
  localparam int PCNT_W      = 5;
  localparam int MSIZE_W     = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Pixel modes; the unused code behaves as indexed
  localparam logic [1:0] MODE_INDEXED = 2'd0;
  localparam logic [1:0] MODE_HAM     = 2'd1;
  localparam logic [1:0] MODE_DIRECT  = 2'd2;

  // HAM actions, taken from bits 5:4 of the pixel value
  localparam logic [1:0] ACT_MAP   = 2'd0;
  localparam logic [1:0] ACT_BLUE  = 2'd1;
  localparam logic [1:0] ACT_RED   = 2'd2;
  localparam logic [1:0] ACT_GREEN = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIZE    = 2'd2;

  localparam logic [PCNT_W-1:0] PLANE_COUNT_RESET = 5'd8;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [1:0]         pixel_mode;
    logic [PCNT_W-1:0]  plane_count;
    logic [MSIZE_W-1:0] map_size;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] waddr;
    rgb_t              wdata;
    logic              re;
    logic [MAP_AW-1:0] raddr;
  } ram_req_t;

  // Repeat a nibble into both halves of a byte
  function automatic logic [COL_W-1:0] rep_nibble(input logic [3:0] v);
    rep_nibble = {v, v};
  endfunction

  // Keep the low n planes; counts above the plane total keep all of them
  function automatic logic [PIX_W-1:0] plane_mask(input logic [PCNT_W-1:0] n);
    logic [PIX_W-1:0] m;
    for (int i = 0; i < PIX_W; i++) begin
      m[i] = (PCNT_W'(i) < n);
    end
    plane_mask = m;
  endfunction

endpackage

// ----- hdl/hpd_if.sv -----
// Channel interfaces of the planar pixel decoder: input beats, result beats, register writes.
// Depends on hpd_pkg for field widths.
interface hpd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [hpd_pkg::MAP_AW-1:0]        map_index;
  logic [hpd_pkg::COL_W-1:0]         map_red;
  logic [hpd_pkg::COL_W-1:0]         map_green;
  logic [hpd_pkg::COL_W-1:0]         map_blue;
  logic [hpd_pkg::PIX_W-1:0]         plane_bits;

  modport source(output valid, req_type, map_index, map_red, map_green, map_blue,
                 plane_bits, input ready);
  modport sink(input valid, req_type, map_index, map_red, map_green, map_blue,
               plane_bits, output ready);
endinterface

interface hpd_out_if;
  logic                      valid;
  logic                      ready;
  logic [hpd_pkg::COL_W-1:0] out_red;
  logic [hpd_pkg::COL_W-1:0] out_green;
  logic [hpd_pkg::COL_W-1:0] out_blue;
  logic [hpd_pkg::COL_W-1:0] out_index;
  logic                      index_error;

  modport source(output valid, out_red, out_green, out_blue, out_index, index_error,
                 input ready);
  modport sink(input valid, out_red, out_green, out_blue, out_index, index_error,
               output ready);
endinterface

interface hpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hpd_pkg::CFG_IDX_W-1:0]  index;
  logic [hpd_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/hpd_cfg_regs.sv -----
// Configuration registers of the planar pixel decoder.
// Depends on hpd_pkg and hpd_cfg_if.
module hpd_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  hpd_cfg_if.sink         cfg_ch,
  output hpd_pkg::cfg_t   cfg
);

  hpd_pkg::cfg_t cfg_r;
  hpd_pkg::cfg_t cfg_nxt;

  // Always take a write beat
  assign cfg_ch.ready = 1'b1;

  // Decode the register index; writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hpd_pkg::CFG_PIXEL_MODE:  cfg_nxt.pixel_mode  = cfg_ch.data[1:0];
        hpd_pkg::CFG_PLANE_COUNT: cfg_nxt.plane_count = cfg_ch.data[hpd_pkg::PCNT_W-1:0];
        hpd_pkg::CFG_MAP_SIZE:    cfg_nxt.map_size    = cfg_ch.data[hpd_pkg::MSIZE_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode  <= hpd_pkg::MODE_INDEXED;
      cfg_r.plane_count <= hpd_pkg::PLANE_COUNT_RESET;
      cfg_r.map_size    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/hpd_colour_ram.sv -----
// Colour map memory: 16 RGB entries, one write and one registered read per cycle.
// Depends on hpd_pkg.
module hpd_colour_ram (
  input  logic              clk,
  input  hpd_pkg::ram_req_t req,
  output hpd_pkg::rgb_t     rd_data
);

  hpd_pkg::rgb_t mem_r [hpd_pkg::MAP_ENTRIES];
  hpd_pkg::rgb_t rd_data_r;

  // Write the loaded entry
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // Registered read; hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/hpd_pixel_pipe.sv -----
// Pixel pipeline: masks plane bits, drives the colour map, resolves HAM against the
// held colour and registers the result beat. Depends on hpd_pkg and the channel interfaces.
module hpd_pixel_pipe (
  input  logic              clk,
  input  logic              rst_n,
  hpd_in_if.sink            in_ch,
  hpd_out_if.source         out_ch,
  input  hpd_pkg::cfg_t     cfg,
  output hpd_pkg::ram_req_t ram_req,
  input  hpd_pkg::rgb_t     ram_rdata
);

  logic                       in_fire;
  logic [hpd_pkg::PIX_W-1:0]  pix_val;

  logic                       s1_valid_r;
  logic                       s1_req_r;
  logic                       s1_load0_r;
  hpd_pkg::rgb_t              s1_col_r;
  logic [hpd_pkg::PIX_W-1:0]  s1_pix_r;
  logic                       s1_fire;
  logic                       out_free;

  hpd_pkg::rgb_t              held_r;
  hpd_pkg::rgb_t              held_nxt;
  hpd_pkg::rgb_t              ham_col;
  hpd_pkg::rgb_t              res_col;
  logic [hpd_pkg::COL_W-1:0]  res_index;
  logic                       res_err;
  logic [3:0]                 nib;

  logic                       out_valid_r;
  hpd_pkg::rgb_t              out_col_r;
  logic [hpd_pkg::COL_W-1:0]  out_index_r;
  logic                       out_err_r;

  // Stage 0: accept a beat, mask the planes, issue the map access
  assign in_fire = in_ch.valid && in_ch.ready;
  assign pix_val = in_ch.plane_bits & hpd_pkg::plane_mask(cfg.plane_count);

  always_comb begin
    ram_req.we          = in_fire && (in_ch.req_type == hpd_pkg::REQ_LOAD);
    ram_req.waddr       = in_ch.map_index;
    ram_req.wdata.red   = in_ch.map_red;
    ram_req.wdata.green = in_ch.map_green;
    ram_req.wdata.blue  = in_ch.map_blue;
    ram_req.re          = in_fire && (in_ch.req_type == hpd_pkg::REQ_PIXEL);
    ram_req.raddr       = pix_val[hpd_pkg::MAP_AW-1:0];
  end

  // Stage 1 advances when the output register is free; loads need no output slot
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && ((s1_req_r == hpd_pkg::REQ_LOAD) || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r       <= in_ch.req_type;
      s1_load0_r     <= (in_ch.map_index == '0);
      s1_col_r.red   <= in_ch.map_red;
      s1_col_r.green <= in_ch.map_green;
      s1_col_r.blue  <= in_ch.map_blue;
      s1_pix_r       <= pix_val;
    end
  end

  // HAM: take the map entry or modify one component of the held colour
  assign nib = s1_pix_r[3:0];

  always_comb begin
    ham_col = held_r;
    case (s1_pix_r[5:4])
      hpd_pkg::ACT_MAP:   ham_col       = ram_rdata;
      hpd_pkg::ACT_BLUE:  ham_col.blue  = hpd_pkg::rep_nibble(nib);
      hpd_pkg::ACT_RED:   ham_col.red   = hpd_pkg::rep_nibble(nib);
      hpd_pkg::ACT_GREEN: ham_col.green = hpd_pkg::rep_nibble(nib);
      default:            ham_col       = held_r;
    endcase
  end

  // Form the result for the configured mode
  always_comb begin
    res_col   = '0;
    res_index = '0;
    res_err   = 1'b0;
    case (cfg.pixel_mode)
      hpd_pkg::MODE_HAM: begin
        res_col = ham_col;
      end
      hpd_pkg::MODE_DIRECT: begin
        res_col.red   = s1_pix_r[23:16];
        res_col.green = s1_pix_r[15:8];
        res_col.blue  = s1_pix_r[7:0];
      end
      default: begin
        res_index = s1_pix_r[hpd_pkg::COL_W-1:0];
        res_err   = (s1_pix_r >= hpd_pkg::PIX_W'(cfg.map_size));
      end
    endcase
  end

  // Held colour follows HAM pixels and loads of entry 0, in beat order
  always_comb begin
    held_nxt = held_r;
    if (s1_fire) begin
      if (s1_req_r == hpd_pkg::REQ_LOAD) begin
        if (s1_load0_r) begin
          held_nxt = s1_col_r;
        end
      end else if (cfg.pixel_mode == hpd_pkg::MODE_HAM) begin
        held_nxt = ham_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  // Output register: load a pixel result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && (s1_req_r == hpd_pkg::REQ_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_req_r == hpd_pkg::REQ_PIXEL)) begin
      out_col_r   <= res_col;
      out_index_r <= res_index;
      out_err_r   <= res_err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_red     = out_col_r.red;
  assign out_ch.out_green   = out_col_r.green;
  assign out_ch.out_blue    = out_col_r.blue;
  assign out_ch.out_index   = out_index_r;
  assign out_ch.index_error = out_err_r;

endmodule

// ----- hdl/ham_planar_pixel_decoder_core.sv -----
// Top level of the planar pixel decoder: configuration registers, colour map, pixel pipeline.
// Depends on hpd_pkg, hpd_if, hpd_cfg_regs, hpd_colour_ram and hpd_pixel_pipe.
//
// Use:
//   in_ch  carries load beats (req_type 0: write one of 16 colour map entries; entry 0
//          also sets the held colour) and pixel beats (req_type 1: plane bits of one pixel).
//   out_ch carries one result beat per pixel beat: RGB in HAM or direct mode, index and
//          range flag in indexed mode. Load beats give no result.
//   cfg_ch writes pixel_mode (0), plane_count (1) and map_size (2); it is always ready.
//          Write it only while the decoder is idle.
// Pipeline and throughput:
//   A pixel beat passes the input stage and stage 1 into the result register; one beat per
//   cycle is sustained while out_ch.ready is high. The colour map memory has a registered
//   read, issued when the beat is taken; its data is used, with the held colour, in stage 1.
// Reset (synchronous, rst_n low): registers to their reset values, held colour to zero,
//   pipeline empty. The colour map is not cleared; entries are undefined until loaded.
// Stall: while out_ch.ready is low the result register holds, and in_ch.ready drops once
//   the stage behind it is also occupied by a pixel beat.
module ham_planar_pixel_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  hpd_in_if.sink      in_ch,
  hpd_out_if.source   out_ch,
  hpd_cfg_if.sink     cfg_ch
);

  hpd_pkg::cfg_t     cfg;
  hpd_pkg::ram_req_t ram_req;
  hpd_pkg::rgb_t     ram_rdata;

  hpd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  hpd_colour_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  hpd_pixel_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg       (cfg),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule

// ----- hdl/hpd_checker.sv -----
// Port-level checks for the planar pixel decoder, bound to the top level.
// Depends on hpd_pkg and ham_planar_pixel_decoder_core.
module hpd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [hpd_pkg::COL_W-1:0] out_red,
  input logic [hpd_pkg::COL_W-1:0] out_green,
  input logic [hpd_pkg::COL_W-1:0] out_blue,
  input logic [hpd_pkg::COL_W-1:0] out_index,
  input logic                      index_error
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // A stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_index) && $stable(index_error))
    else $error("stalled result beat changed");

  // Indexed results carry no colour
  a_index_no_rgb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (index_error || (out_index != '0)) |->
      (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("indexed result with colour");

  // A result appearing in an empty register comes from an input beat that passed through stage 1
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without input beat");

endmodule

bind ham_planar_pixel_decoder_core hpd_checker u_hpd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_red     (out_ch.out_red),
  .out_green   (out_ch.out_green),
  .out_blue    (out_ch.out_blue),
  .out_index   (out_ch.out_index),
  .index_error (out_ch.index_error)
);
